>>> design/bmu_pkg.sv
package bmu_pkg;

	// Mixer kinds held in the configuration register
	localparam logic [2:0] KIND_SPLITMIX = 3'd0;
	localparam logic [2:0] KIND_MURMUR3  = 3'd1;
	localparam logic [2:0] KIND_MOREMUR  = 3'd2;
	localparam logic [2:0] KIND_RRMXMX   = 3'd3;
	localparam logic [2:0] KIND_IDENTITY = 3'd4;
	localparam logic [2:0] KIND_XORSHIFT = 3'd5;

	// Direction carried with each request
	localparam logic CMD_FWD = 1'b0;
	localparam logic CMD_INV = 1'b1;

	localparam logic [63:0] MUL_SM_A = 64'hBF58476D1CE4E5B9;
	localparam logic [63:0] MUL_SM_B = 64'h94D049BB133111EB;
	localparam logic [63:0] MUL_MM_A = 64'hFF51AFD7ED558CCD;
	localparam logic [63:0] MUL_MM_B = 64'hC4CEB9FE1A85EC53;
	localparam logic [63:0] MUL_MO_A = 64'h3C79AC492BA7B653;
	localparam logic [63:0] MUL_MO_B = 64'h1C69B3F74AC4AE35;
	localparam logic [63:0] MUL_RR   = 64'h9FB21C651E98DF25;

	// Rotate-xor step as a polynomial mod x^64+1: v ^ rotl(v,15) ^ rotl(v,40)
	localparam logic [63:0] ROTXOR_NIL_MASK = (64'd1 << 15) | (64'd1 << 40);
	localparam logic [63:0] ROTXOR_FWD_MASK = ROTXOR_NIL_MASK | 64'd1;

	typedef enum logic [2:0] {
		OP_NONE,
		OP_XS,
		OP_UXS,
		OP_RXF,
		OP_RXI
	} step_op_t;

	typedef struct packed {
		step_op_t    op;
		logic [5:0]  sh;
	} step_t;

	typedef struct packed {
		step_t       a;
		logic [63:0] m1;
		step_t       b;
		logic [63:0] m2;
		step_t       c;
	} plan_t;

	typedef struct packed {
		logic        inv;
		logic [2:0]  kind;
	} item_ctrl_t;

	// Inverse of an odd value mod 2^64 by Newton iteration
	function automatic logic [63:0] odd_inverse(logic [63:0] m);
		logic [63:0] t;
		t = m;
		for (int k = 0; k < 6; k++) begin
			t = t * (64'd2 - m * t);
		end
		return t;
	endfunction

	// Product of two polynomials mod x^64+1 over GF(2): XOR of rotated copies
	function automatic logic [63:0] poly_mul(logic [63:0] a, logic [63:0] b);
		logic [63:0] r;
		r = 64'd0;
		for (int i = 0; i < 64; i++) begin
			if (b[i]) begin
				r = r ^ ((a << i) | (a >> (64 - i)));
			end
		end
		return r;
	endfunction

	// Sum of powers 0..63 of the nilpotent part undoes the rotate-xor step
	function automatic logic [63:0] rotxor_inv_mask();
		logic [63:0] acc;
		logic [63:0] pw;
		acc = 64'd1;
		pw  = 64'd1;
		for (int k = 1; k < 64; k++) begin
			pw  = poly_mul(pw, ROTXOR_NIL_MASK);
			acc = acc ^ pw;
		end
		return acc;
	endfunction

	localparam logic [63:0] ROTXOR_INV_MASK = rotxor_inv_mask();

	localparam logic [63:0] INV_SM_A = odd_inverse(MUL_SM_A);
	localparam logic [63:0] INV_SM_B = odd_inverse(MUL_SM_B);
	localparam logic [63:0] INV_MM_A = odd_inverse(MUL_MM_A);
	localparam logic [63:0] INV_MM_B = odd_inverse(MUL_MM_B);
	localparam logic [63:0] INV_MO_A = odd_inverse(MUL_MO_A);
	localparam logic [63:0] INV_MO_B = odd_inverse(MUL_MO_B);
	localparam logic [63:0] INV_RR   = odd_inverse(MUL_RR);

	function automatic step_t mk_step(step_op_t op, logic [5:0] sh);
		step_t s;
		s.op = op;
		s.sh = sh;
		return s;
	endfunction

	// Apply one xor-type step; all shift amounts used are at least 22,
	// so three terms close the inverse xorshift
	function automatic logic [63:0] apply_step(logic [63:0] v, step_t st);
		logic [63:0] r;
		case (st.op)
			OP_XS:   r = v ^ (v >> st.sh);
			OP_UXS:  r = v ^ (v >> st.sh) ^ (v >> {st.sh, 1'b0});
			OP_RXF:  r = poly_mul(v, ROTXOR_FWD_MASK);
			OP_RXI:  r = poly_mul(v, ROTXOR_INV_MASK);
			default: r = v;
		endcase
		return r;
	endfunction

	function automatic plan_t decode_plan(item_ctrl_t c);
		plan_t p;
		p.a  = mk_step(OP_NONE, 6'd0);
		p.m1 = 64'd1;
		p.b  = mk_step(OP_NONE, 6'd0);
		p.m2 = 64'd1;
		p.c  = mk_step(OP_NONE, 6'd0);
		case (c.kind)
			KIND_SPLITMIX: begin
				if (c.inv == CMD_FWD) begin
					p.a = mk_step(OP_XS, 6'd30); p.m1 = MUL_SM_A;
					p.b = mk_step(OP_XS, 6'd27); p.m2 = MUL_SM_B;
					p.c = mk_step(OP_XS, 6'd31);
				end else begin
					p.a = mk_step(OP_UXS, 6'd31); p.m1 = INV_SM_B;
					p.b = mk_step(OP_UXS, 6'd27); p.m2 = INV_SM_A;
					p.c = mk_step(OP_UXS, 6'd30);
				end
			end
			KIND_MURMUR3: begin
				if (c.inv == CMD_FWD) begin
					p.a = mk_step(OP_XS, 6'd33); p.m1 = MUL_MM_A;
					p.b = mk_step(OP_XS, 6'd33); p.m2 = MUL_MM_B;
					p.c = mk_step(OP_XS, 6'd33);
				end else begin
					p.a = mk_step(OP_UXS, 6'd33); p.m1 = INV_MM_B;
					p.b = mk_step(OP_UXS, 6'd33); p.m2 = INV_MM_A;
					p.c = mk_step(OP_UXS, 6'd33);
				end
			end
			KIND_MOREMUR: begin
				if (c.inv == CMD_FWD) begin
					p.a = mk_step(OP_XS, 6'd27); p.m1 = MUL_MO_A;
					p.b = mk_step(OP_XS, 6'd33); p.m2 = MUL_MO_B;
					p.c = mk_step(OP_XS, 6'd27);
				end else begin
					p.a = mk_step(OP_UXS, 6'd27); p.m1 = INV_MO_B;
					p.b = mk_step(OP_UXS, 6'd33); p.m2 = INV_MO_A;
					p.c = mk_step(OP_UXS, 6'd27);
				end
			end
			KIND_RRMXMX: begin
				if (c.inv == CMD_FWD) begin
					p.a = mk_step(OP_RXF, 6'd0); p.m1 = MUL_RR;
					p.b = mk_step(OP_XS, 6'd28); p.m2 = MUL_RR;
					p.c = mk_step(OP_XS, 6'd28);
				end else begin
					p.a = mk_step(OP_UXS, 6'd28); p.m1 = INV_RR;
					p.b = mk_step(OP_UXS, 6'd28); p.m2 = INV_RR;
					p.c = mk_step(OP_RXI, 6'd0);
				end
			end
			KIND_XORSHIFT: begin
				if (c.inv == CMD_FWD) begin
					p.a = mk_step(OP_XS, 6'd30);
					p.b = mk_step(OP_XS, 6'd27);
					p.c = mk_step(OP_XS, 6'd31);
				end else begin
					p.a = mk_step(OP_UXS, 6'd31);
					p.b = mk_step(OP_UXS, 6'd27);
					p.c = mk_step(OP_UXS, 6'd30);
				end
			end
			default: begin
				p.m1 = 64'd1;
			end
		endcase
		return p;
	endfunction

endpackage

>>> design/bijective_mix_and_unmix_64_top.sv
// Stateless 64-bit bijective mixer with its exact inverse. Each request on the s_ stream
// carries a word (s_tdata) and a direction bit (s_tuser: 0 forward, 1 inverse); the result
// leaves on the m_ stream in request order. The cfg channel selects the mixer kind
// (0 splitmix64, 1 murmur3 fmix64, 2 moremur, 3 rrmxmx, 4 identity, 5 xorshift only,
// 6 and 7 pass the word through); write it only while no request is in flight. The datapath
// is a seven-stage pipeline: first xor step, partial products, sum, middle xor step,
// partial products, sum, last xor step. A new request is taken every cycle while the
// output is not stalled; the stage count is set by the two 64-bit multiplies, each cut
// into three 32x32 partial products in one stage and their sum in the next. When m_tready
// is low, empty stages still fill; up to seven results can be held before s_tready drops.
module bijective_mix_and_unmix_64_top (
	input  logic        clk,
	input  logic        arst_n,
	// configuration write channel
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_data,      // [2:0] mixer_kind
	// request stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,       // [63:0] word_in
	input  logic [0:0]  s_tuser,       // [0] command
	// result stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [63:0] m_tdata        // [63:0] word_out
);

	logic [2:0] mixer_kind_q;

	// stage valid bits
	logic valid_s1, valid_s2, valid_s3, valid_s4, valid_s5, valid_s6, valid_s7;
	// per-stage load enables: a stage loads when empty or when the next one loads
	logic adv1, adv2, adv3, adv4, adv5, adv6, adv7;

	bmu_pkg::item_ctrl_t ctrl_in;
	bmu_pkg::item_ctrl_t ctrl_s1, ctrl_s2, ctrl_s3, ctrl_s4, ctrl_s5, ctrl_s6;
	bmu_pkg::plan_t      plan_in, plan_s1, plan_s3, plan_s4, plan_s6;

	logic [63:0] word_s1, word_s3, word_s4, word_s6, word_s7;
	logic [63:0] pp_ll_s2, pp_ll_s5;
	logic [31:0] pp_lh_s2, pp_hl_s2, pp_lh_s5, pp_hl_s5;

	// Register write: always ready, keep the low three bits
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mixer_kind_q <= bmu_pkg::KIND_SPLITMIX;
		end else if (cfg_valid && cfg_ready) begin
			mixer_kind_q <= cfg_data;
		end
	end

	// Backpressure chain: bubbles are squeezed out while the output waits
	always_comb begin
		adv7 = !valid_s7 || m_tready;
		adv6 = !valid_s6 || adv7;
		adv5 = !valid_s5 || adv6;
		adv4 = !valid_s4 || adv5;
		adv3 = !valid_s3 || adv4;
		adv2 = !valid_s2 || adv3;
		adv1 = !valid_s1 || adv2;
	end

	assign s_tready = adv1;
	assign m_tvalid = valid_s7;
	assign m_tdata  = word_s7;

	// Decode the plan from kind and direction at each stage that needs it
	always_comb begin
		ctrl_in.inv  = s_tuser[0];
		ctrl_in.kind = mixer_kind_q;
		plan_in = bmu_pkg::decode_plan(ctrl_in);
		plan_s1 = bmu_pkg::decode_plan(ctrl_s1);
		plan_s3 = bmu_pkg::decode_plan(ctrl_s3);
		plan_s4 = bmu_pkg::decode_plan(ctrl_s4);
		plan_s6 = bmu_pkg::decode_plan(ctrl_s6);
	end

	// Valid bits advance with their stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
			valid_s6 <= 1'b0;
			valid_s7 <= 1'b0;
		end else begin
			if (adv1) valid_s1 <= s_tvalid;
			if (adv2) valid_s2 <= valid_s1;
			if (adv3) valid_s3 <= valid_s2;
			if (adv4) valid_s4 <= valid_s3;
			if (adv5) valid_s5 <= valid_s4;
			if (adv6) valid_s6 <= valid_s5;
			if (adv7) valid_s7 <= valid_s6;
		end
	end

	// Datapath: load a stage only when it advances and a request sits upstream
	always_ff @(posedge clk) begin
		// stage 1: first xor step (xorshift, inverse xorshift or rotate-xor)
		if (adv1 && s_tvalid) begin
			word_s1 <= bmu_pkg::apply_step(s_tdata, plan_in.a);
			ctrl_s1 <= ctrl_in;
		end
		// stage 2: partial products of the first multiply, low 64 bits only
		if (adv2 && valid_s1) begin
			pp_ll_s2 <= 64'(word_s1[31:0]) * 64'(plan_s1.m1[31:0]);
			pp_lh_s2 <= word_s1[31:0] * plan_s1.m1[63:32];
			pp_hl_s2 <= word_s1[63:32] * plan_s1.m1[31:0];
			ctrl_s2  <= ctrl_s1;
		end
		// stage 3: sum of partial products
		if (adv3 && valid_s2) begin
			word_s3 <= pp_ll_s2 + {pp_lh_s2 + pp_hl_s2, 32'd0};
			ctrl_s3 <= ctrl_s2;
		end
		// stage 4: middle xor step
		if (adv4 && valid_s3) begin
			word_s4 <= bmu_pkg::apply_step(word_s3, plan_s3.b);
			ctrl_s4 <= ctrl_s3;
		end
		// stage 5: partial products of the second multiply
		if (adv5 && valid_s4) begin
			pp_ll_s5 <= 64'(word_s4[31:0]) * 64'(plan_s4.m2[31:0]);
			pp_lh_s5 <= word_s4[31:0] * plan_s4.m2[63:32];
			pp_hl_s5 <= word_s4[63:32] * plan_s4.m2[31:0];
			ctrl_s5  <= ctrl_s4;
		end
		// stage 6: sum of partial products
		if (adv6 && valid_s5) begin
			word_s6 <= pp_ll_s5 + {pp_lh_s5 + pp_hl_s5, 32'd0};
			ctrl_s6 <= ctrl_s5;
		end
		// stage 7: last xor step into the output register
		if (adv7 && valid_s6) begin
			word_s7 <= bmu_pkg::apply_step(word_s6, plan_s6.c);
		end
	end

endmodule

>>> design/bmu_checker.sv
module bmu_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        cfg_valid,
	input logic        cfg_ready,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [63:0] m_tdata
);

	// hold a stalled result
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("result dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata))
		else $error("stalled result changed");

	// a free output stage must open the input side
	a_in_open: assert property (@(posedge clk) disable iff (!arst_n)
		(!m_tvalid || m_tready) |-> s_tready)
		else $error("input blocked while output drains");

	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |-> cfg_ready)
		else $error("register write refused");

endmodule

bind bijective_mix_and_unmix_64_top bmu_checker u_bmu_checker (.*);
